// ----- rtl/ffsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsc_pkg
// Shared types, constants and the reflected CRC-8 byte step for the frame sync.
// ----------------------------------------------------------------------------
package ffsc_pkg;

  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned CRC_LEN   = 9;
  localparam logic [7:0]  CRC_POLY  = 8'h8C;

  localparam logic [7:0] MIN_ID_RESET = 8'h01;
  localparam logic [7:0] MAX_ID_RESET = 8'h04;

  localparam logic [7:0] REG_MIN_ID = 8'd0;
  localparam logic [7:0] REG_MAX_ID = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CRC   = 3'b010,
    ST_CHECK = 3'b100
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
  } crc_ctl_t;

  // One byte through the reflected CRC, eight bit steps.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/ffsc_crc_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsc_crc_unit
// Shared CRC accumulator that folds in one window byte per step.
// ----------------------------------------------------------------------------
module ffsc_crc_unit
  import ffsc_pkg::*;
(
  input  logic       clk,
  input  crc_ctl_t   ctl,
  input  logic [7:0] data,
  output logic [7:0] crc
);

  logic [7:0] crc_r;
  logic [7:0] crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    if (ctl.clear) begin
      crc_nxt = 8'h00;
    end else if (ctl.step) begin
      crc_nxt = crc8_byte(crc_r, data);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule

// ----- rtl/feedback_frame_sync_crc8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_frame_sync_crc8
// Ten-byte motor feedback frame synchronizer with a reflected CRC-8 check.
// ----------------------------------------------------------------------------
// Received bytes arrive on the in_ channel, one per transfer. The block keeps
// a window of up to ten bytes. A byte that does not complete the window
// leaves in_stall low. A byte that completes the window starts the check:
// the shared CRC unit folds in one of the nine covered bytes per cycle, then
// the check state compares the result with the tenth byte and the first byte
// with the ID range; in_stall stays high throughout. On a match the decoded
// frame is loaded into the output register, out_valid rises and the window
// empties; otherwise the oldest byte is dropped. A frame waits in the output
// register until its transfer, and the input side keeps working meanwhile;
// only a second match while a frame still waits holds the block in the check.
// Reset (rst_n low, synchronous) empties the window, clears out_valid and
// sets min_id to 1 and max_id to 4. The cfg_ port writes min_id (index 0) and
// max_id (index 1); other indexes are ignored. The user must write them only
// while the block is idle; the block itself has no check for it.
// ----------------------------------------------------------------------------
module feedback_frame_sync_crc8
  import ffsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_unit_id,
  output logic [7:0]         out_run_mode,
  output logic signed [15:0] out_torque,
  output logic signed [15:0] out_velocity,
  output logic [15:0]        out_position,
  output logic [7:0]         out_fault_code
);

  state_t     state_r, state_nxt;
  logic [3:0] fill_r, fill_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [7:0] min_id_r, max_id_r;
  logic [7:0] win_r [FRAME_LEN];
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] frame_r [CRC_LEN];

  logic       in_xfer, out_xfer;
  logic       match, can_load, do_load, do_drop;
  crc_ctl_t   crc_ctl;
  logic [7:0] crc;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  ffsc_crc_unit u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (win_r[idx_r]),
    .crc  (crc)
  );

  assign match    = (win_r[0] >= min_id_r) && (win_r[0] <= max_id_r) &&
                    (crc == win_r[FRAME_LEN-1]);
  assign can_load = !out_valid_r || !out_stall;
  assign do_load  = (state_r == ST_CHECK) && match && can_load;
  assign do_drop  = (state_r == ST_CHECK) && !match;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    crc_ctl       = '0;
    out_valid_nxt = out_valid_r && !out_xfer;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          fill_nxt = fill_r + 4'd1;
          if (fill_r == 4'(FRAME_LEN - 1)) begin
            state_nxt     = ST_CRC;
            idx_nxt       = 4'd0;
            crc_ctl.clear = 1'b1;
          end
        end
      end
      ST_CRC: begin
        crc_ctl.step = 1'b1;
        idx_nxt      = idx_r + 4'd1;
        if (idx_r == 4'(CRC_LEN - 1)) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (do_load) begin
          out_valid_nxt = 1'b1;
          fill_nxt      = 4'd0;
          state_nxt     = ST_IDLE;
        end else if (do_drop) begin
          fill_nxt  = 4'(FRAME_LEN - 1);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= 4'd0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
      min_id_r    <= MIN_ID_RESET;
      max_id_r    <= MAX_ID_RESET;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == REG_MIN_ID)) begin
        min_id_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == REG_MAX_ID)) begin
        max_id_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      win_r[fill_r] <= in_rx_byte;
    end else if (do_drop) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[FRAME_LEN-1] <= 8'h00;
    end
    if (do_load) begin
      for (int i = 0; i < CRC_LEN; i++) begin
        frame_r[i] <= win_r[i];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_unit_id    = frame_r[0];
  assign out_run_mode   = frame_r[1];
  assign out_torque     = {frame_r[2], frame_r[3]};
  assign out_velocity   = {frame_r[4], frame_r[5]};
  assign out_position   = {frame_r[6], frame_r[7]};
  assign out_fault_code = frame_r[8];

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 4'(FRAME_LEN))
    else $error("window fill beyond frame length");

  a_full_starts_crc: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (fill_r == 4'(FRAME_LEN - 1)) |=> (state_r == ST_CRC) && (idx_r == 4'd0))
    else $error("completed window did not start the CRC pass");

  a_crc_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CRC) && (idx_r == 4'(CRC_LEN - 1)) |=> (state_r == ST_CHECK))
    else $error("CRC pass did not end in the check");

  a_out_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_CHECK) && (fill_r == 4'd0))
    else $error("frame emitted outside a successful check");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the ten-byte feedback frame synchronizer.
// ----------------------------------------------------------------------------
// Received bytes are pushed through the in_ channel while a byte-level model
// of the window predicts which transfers complete a frame with a valid start
// ID and a matching reflected CRC-8. Predicted frames are compared field by
// field with every out_ transfer. The run walks through several ID ranges
// (reset default, full, empty, single values at both ends, random). It mixes
// clean frames with corrupted ones and stray bytes, and uses random idle
// bursts on both channels plus one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;
  import ffsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned LONG_HOLD     = 400;
  localparam logic [7:0]  REG_UNUSED_LO = 8'd2;
  localparam logic [7:0]  REG_UNUSED_HI = 8'hFF;

  typedef struct {
    logic [7:0]         unit_id;
    logic [7:0]         run_mode;
    logic signed [15:0] torque;
    logic signed [15:0] velocity;
    logic [15:0]        position;
    logic [7:0]         fault_code;
  } feedback_frame_t;

  class frame_tracker;
    logic [7:0]      min_id;
    logic [7:0]      max_id;
    logic [7:0]      win[FRAME_LEN];
    int unsigned     fill;
    int unsigned     mismatches;
    feedback_frame_t awaited_frames[$];

    function new();
      min_id = MIN_ID_RESET;
      max_id = MAX_ID_RESET;
      foreach (win[i]) win[i] = '0;
      fill = 0;
      mismatches = 0;
    endfunction

    static function logic [7:0] crc_over(logic [8*CRC_LEN-1:0] data);
      logic [7:0] c;
      logic       fb;
      c = 8'h00;
      for (int i = 0; i < 8 * CRC_LEN; i++) begin
        fb = c[0] ^ data[i];
        c = c >> 1;
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] val);
      if (idx == REG_MIN_ID) begin
        min_id = val;
      end else if (idx == REG_MAX_ID) begin
        max_id = val;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [8*CRC_LEN-1:0] body;
      feedback_frame_t      f;
      if (fill < FRAME_LEN) begin
        win[fill] = b;
        fill++;
      end
      if (fill < FRAME_LEN) begin
        return;
      end
      for (int i = 0; i < CRC_LEN; i++) begin
        body[8*i +: 8] = win[i];
      end
      if (win[0] >= min_id && win[0] <= max_id && crc_over(body) == win[CRC_LEN]) begin
        f.unit_id    = win[0];
        f.run_mode   = win[1];
        f.torque     = {win[2], win[3]};
        f.velocity   = {win[4], win[5]};
        f.position   = {win[6], win[7]};
        f.fault_code = win[8];
        awaited_frames = {awaited_frames, f};
        fill = 0;
      end else begin
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
          win[i] = win[i+1];
        end
        win[FRAME_LEN-1] = '0;
        fill = FRAME_LEN - 1;
      end
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_frame(feedback_frame_t got);
      feedback_frame_t want;
      if (awaited_frames.size() == 0) begin
        $error("Unexpected frame transfer with unit_id %0d.", got.unit_id);
        mismatches++;
        return;
      end
      want = awaited_frames.pop_front();
      compare_field("unit_id", 32'(want.unit_id), 32'(got.unit_id));
      compare_field("run_mode", 32'(want.run_mode), 32'(got.run_mode));
      compare_field("torque", 32'(want.torque), 32'(got.torque));
      compare_field("velocity", 32'(want.velocity), 32'(got.velocity));
      compare_field("position", 32'(want.position), 32'(got.position));
      compare_field("fault_code", 32'(want.fault_code), 32'(got.fault_code));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [7:0]         cfg_index;
  logic [7:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_unit_id;
  logic [7:0]         out_run_mode;
  logic signed [15:0] out_torque;
  logic signed [15:0] out_velocity;
  logic [15:0]        out_position;
  logic [7:0]         out_fault_code;

  frame_tracker frames = new();
  int unsigned  cycle_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  tx_calm = 0;
  int unsigned  rx_hold = 0;
  int unsigned  rx_burst = 0;
  int unsigned  rx_calm = 0;
  bit           quiet = 1'b0;

  feedback_frame_sync_crc8 u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_unit_id   (out_unit_id),
    .out_run_mode  (out_run_mode),
    .out_torque    (out_torque),
    .out_velocity  (out_velocity),
    .out_position  (out_position),
    .out_fault_code(out_fault_code)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** feedback_frame_sync_crc8: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    feedback_frame_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.unit_id    = out_unit_id;
      got.run_mode   = out_run_mode;
      got.torque     = out_torque;
      got.velocity   = out_velocity;
      got.position   = out_position;
      got.fault_code = out_fault_code;
      frames.check_frame(got);
    end
  end

  // The receiver stalls in random bursts, separated by calm stretches.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else if (rx_burst > 0) begin
        out_stall <= 1'b1;
        rx_burst--;
      end else if (quiet || rx_calm > 0) begin
        out_stall <= 1'b0;
        if (rx_calm > 0) begin
          rx_calm--;
        end
      end else begin
        out_stall <= 1'b1;
        rx_burst = $urandom_range(8, 1) - 1;
        rx_calm = $urandom_range(40, 0);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    frames.note_byte(b);
    bytes_sent++;
    if (!quiet) begin
      if (tx_calm > 0) begin
        tx_calm--;
      end else if ($urandom_range(5, 0) == 0) begin
        gap = $urandom_range(8, 1);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        tx_calm = $urandom_range(60, 0);
      end
    end
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] mode,
                            input logic [15:0] torque, input logic [15:0] vel,
                            input logic [15:0] pos, input logic [7:0] err,
                            input bit bad_crc);
    logic [8*CRC_LEN-1:0] body;
    logic [7:0]           crc;
    body = {err, pos[7:0], pos[15:8], vel[7:0], vel[15:8],
            torque[7:0], torque[15:8], mode, id};
    crc = frame_tracker::crc_over(body);
    if (bad_crc) begin
      crc = crc ^ 8'($urandom_range(255, 1));
    end
    for (int i = 0; i < CRC_LEN; i++) begin
      send_byte(body[8*i +: 8]);
    end
    send_byte(crc);
  endtask

  task automatic send_random_frame(input logic [7:0] id, input bit bad_crc);
    send_frame(id, 8'($urandom_range(255, 0)), 16'($urandom_range(65535, 0)),
               16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
               ($urandom_range(3, 0) == 0) ? 8'($urandom_range(255, 1)) : 8'h00,
               bad_crc);
  endtask

  function automatic logic [7:0] in_range_id();
    if (frames.min_id <= frames.max_id) begin
      return 8'($urandom_range(frames.max_id, frames.min_id));
    end
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic logic [7:0] out_of_range_id();
    if (frames.min_id > frames.max_id) begin
      return 8'($urandom_range(255, 0));
    end
    if (frames.min_id > 0 && (frames.max_id == 8'hFF || $urandom_range(1, 0) == 0)) begin
      return 8'($urandom_range(frames.min_id - 1, 0));
    end
    if (frames.max_id < 8'hFF) begin
      return 8'($urandom_range(255, frames.max_id + 1));
    end
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic run_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(9, 0);
      if (pick < 7) begin
        send_random_frame(in_range_id(), 1'b0);
      end else if (pick == 7) begin
        send_random_frame(in_range_id(), 1'b1);
      end else if (pick == 8) begin
        send_random_frame(out_of_range_id(), 1'b0);
      end else begin
        repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255, 0)));
      end
    end
  endtask

  // A byte that completes the window may still be in its check after the
  // last frame has arrived, so the drain waits a little longer.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames.awaited_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    frames.set_reg(idx, val);
  endtask

  task automatic set_id_range(input logic [7:0] lo, input logic [7:0] hi);
    drain_results();
    write_reg(REG_MIN_ID, lo);
    write_reg(REG_MAX_ID, hi);
  endtask

  initial begin
    logic [7:0] lo;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_UNUSED_LO, 8'h00);
    write_reg(REG_UNUSED_HI, 8'hFF);

    send_frame(MIN_ID_RESET, 8'h00, 16'h8000, 16'h7FFF, 16'h0000, 8'h00, 1'b0);
    send_frame(MAX_ID_RESET, 8'hFF, 16'h7FFF, 16'h8000, 16'hFFFF, 8'hFF, 1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(MAX_ID_RESET + 8'd1);
    send_byte(8'h00);
    run_traffic(200);

    set_id_range(8'h00, 8'hFF);
    rx_hold = LONG_HOLD;
    repeat (5) send_random_frame(in_range_id(), 1'b0);
    drain_results();
    run_traffic(200);

    set_id_range(8'hFF, 8'h00);
    run_traffic(200);

    set_id_range(8'h00, 8'h00);
    run_traffic(200);

    set_id_range(8'hFF, 8'hFF);
    run_traffic(200);

    lo = 8'($urandom_range(255, 0));
    set_id_range(lo, 8'($urandom_range(255, lo)));
    quiet = 1'b1;
    run_traffic(210);

    drain_results();
    if (frames.mismatches == 0) begin
      $display("** feedback_frame_sync_crc8: PASSED **");
    end else begin
      $display("** feedback_frame_sync_crc8: FAILED **");
    end
    $finish;
  end

endmodule

// ----- feedback_frame_sync_crc8.f -----
rtl/ffsc_pkg.sv
rtl/ffsc_crc_unit.sv
rtl/feedback_frame_sync_crc8.sv
test/tb_top.sv
